// File: src/best_pkg.sv
package best_pkg;

	// Widths of the stream payloads.
	localparam int FUNC_W     = 4;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 120;

	// Operation codes carried in the input tuser.
	localparam logic [FUNC_W-1:0] FN_KEY_DOWN   = 4'd0;
	localparam logic [FUNC_W-1:0] FN_KEY_UP     = 4'd1;
	localparam logic [FUNC_W-1:0] FN_MOUSE_DOWN = 4'd2;
	localparam logic [FUNC_W-1:0] FN_MOUSE_UP   = 4'd3;
	localparam logic [FUNC_W-1:0] FN_JOY_DOWN   = 4'd4;
	localparam logic [FUNC_W-1:0] FN_JOY_UP     = 4'd5;
	localparam logic [FUNC_W-1:0] FN_MOVE       = 4'd6;
	localparam logic [FUNC_W-1:0] FN_WHEEL      = 4'd7;
	localparam logic [FUNC_W-1:0] FN_AXIS       = 4'd8;
	localparam logic [FUNC_W-1:0] FN_TICK       = 4'd9;
	localparam logic [FUNC_W-1:0] FN_READ_KEY   = 4'd10;
	localparam logic [FUNC_W-1:0] FN_READ_MOUSE = 4'd11;
	localparam logic [FUNC_W-1:0] FN_READ_JOY   = 4'd12;
	localparam logic [FUNC_W-1:0] FN_SET_OLD_X  = 4'd13;
	localparam logic [FUNC_W-1:0] FN_SET_OLD_Y  = 4'd14;
	localparam logic [FUNC_W-1:0] FN_RESYNC     = 4'd15;

	// Button edge states.
	localparam logic [1:0] ST_UP       = 2'd0;
	localparam logic [1:0] ST_DOWN     = 2'd1;
	localparam logic [1:0] ST_PRESSED  = 2'd2;
	localparam logic [1:0] ST_RELEASED = 2'd3;

	// Bit positions in the edge flag register.
	localparam int FLAG_PRESSED  = 0;
	localparam int FLAG_RELEASED = 1;
	localparam int FLAG_DOWN     = 2;

	// One classified transaction as it travels through the queue.
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              hit;
		logic [7:0]        idx;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] value;
	} item_t;

	// End-of-frame ageing: pressed becomes down, released becomes up.
	function automatic logic [1:0] age_state(input logic [1:0] s);
		logic [1:0] r;
		r = s;
		if (s == ST_PRESSED) begin
			r = ST_DOWN;
		end else if (s == ST_RELEASED) begin
			r = ST_UP;
		end
		return r;
	endfunction

endpackage

// File: src/best_front.sv
module best_front #(
	parameter int KEY_COUNT     = 256,
	parameter int MOUSE_BUTTONS = 4,
	parameter int JOY_BUTTONS   = 12
) (
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [best_pkg::IN_DATA_W-1:0] s_tdata,
	input  logic [best_pkg::FUNC_W-1:0]   s_tuser,
	input  logic                          full,
	output logic                          push,
	output best_pkg::item_t               item
);

	logic [8:0] idx_w;

	// Take a transaction whenever the queue has room.
	assign s_tready = !full;
	assign push     = s_tvalid && !full;
	assign idx_w    = {1'b0, s_tdata[7:0]};

	// Unpack the fields and decide whether the index addresses a real entry.
	always_comb begin
		item.func  = s_tuser;
		item.idx   = s_tdata[7:0];
		item.pos_x = s_tdata[23:8];
		item.pos_y = s_tdata[39:24];
		item.value = s_tdata[55:40];
		unique case (s_tuser)
			best_pkg::FN_KEY_DOWN, best_pkg::FN_KEY_UP, best_pkg::FN_READ_KEY: begin
				item.hit = idx_w < 9'(KEY_COUNT);
			end
			best_pkg::FN_MOUSE_DOWN, best_pkg::FN_MOUSE_UP, best_pkg::FN_READ_MOUSE: begin
				item.hit = idx_w < 9'(MOUSE_BUTTONS);
			end
			best_pkg::FN_JOY_DOWN, best_pkg::FN_JOY_UP, best_pkg::FN_READ_JOY: begin
				item.hit = idx_w < 9'(JOY_BUTTONS);
			end
			best_pkg::FN_AXIS: begin
				item.hit = idx_w < 9'd2;
			end
			default: begin
				item.hit = 1'b0;
			end
		endcase
	end

endmodule

// File: src/best_fifo.sv
module best_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  best_pkg::item_t wr_item,
	output logic            full,
	input  logic            pop,
	output best_pkg::item_t head,
	output logic            head_valid
);

	best_pkg::item_t ent_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;

	assign full       = cnt_q == 2'd2;
	assign head_valid = cnt_q != 2'd0;
	assign head       = ent_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

// File: src/best_back.sv
module best_back #(
	parameter int KEY_COUNT     = 256,
	parameter int MOUSE_BUTTONS = 4,
	parameter int JOY_BUTTONS   = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  best_pkg::item_t                 head,
	input  logic                            head_valid,
	output logic                            pop,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [best_pkg::OUT_DATA_W-1:0] m_tdata
);

	localparam int KEY_AW   = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
	localparam int MOUSE_AW = (MOUSE_BUTTONS > 1) ? $clog2(MOUSE_BUTTONS) : 1;
	localparam int JOY_AW   = (JOY_BUTTONS > 1) ? $clog2(JOY_BUTTONS) : 1;

	localparam logic BK_IDLE = 1'b0;
	localparam logic BK_KEY  = 1'b1;

	logic state_q;

	logic [1:0]           key_mem [KEY_COUNT];
	logic [1:0]           key_rd_q;
	logic [KEY_COUNT-1:0] key_valid_q;
	logic [KEY_COUNT-1:0] key_fresh_q;
	logic [1:0]           mouse_q [MOUSE_BUTTONS];
	logic [1:0]           joy_q [JOY_BUTTONS];

	logic signed [15:0] cursor_x_q, cursor_y_q, old_x_q, old_y_q;
	logic signed [15:0] wheel_q, axis_x_q, axis_y_q;
	logic signed [16:0] dx_q, dy_q;
	logic               resync_q;
	logic [2:0]         flags_q;

	logic                            m_tvalid_q;
	logic [best_pkg::OUT_DATA_W-1:0] m_tdata_q;

	logic [KEY_AW-1:0]   key_addr;
	logic [MOUSE_AW-1:0] mouse_addr;
	logic [JOY_AW-1:0]   joy_addr;
	logic is_key, is_mouse, is_joy, is_press, is_release, is_read, is_tick;
	logic out_free, key_re, key_we, done;
	logic [1:0] key_eff, cur, new_state, bs;
	logic press_hit, rel_hit, upd;

	logic signed [15:0] nxt_cx, nxt_cy, nxt_ox, nxt_oy, nxt_wheel, nxt_ax, nxt_ay;
	logic signed [16:0] nxt_dx, nxt_dy;
	logic               nxt_resync;
	logic [2:0]         nxt_flags;

	assign key_addr   = head.idx[KEY_AW-1:0];
	assign mouse_addr = head.idx[MOUSE_AW-1:0];
	assign joy_addr   = head.idx[JOY_AW-1:0];

	// Classify the operation at the head of the queue.
	assign is_key   = head.func == best_pkg::FN_KEY_DOWN || head.func == best_pkg::FN_KEY_UP
		|| head.func == best_pkg::FN_READ_KEY;
	assign is_mouse = head.func == best_pkg::FN_MOUSE_DOWN || head.func == best_pkg::FN_MOUSE_UP
		|| head.func == best_pkg::FN_READ_MOUSE;
	assign is_joy   = head.func == best_pkg::FN_JOY_DOWN || head.func == best_pkg::FN_JOY_UP
		|| head.func == best_pkg::FN_READ_JOY;
	assign is_press = head.func == best_pkg::FN_KEY_DOWN || head.func == best_pkg::FN_MOUSE_DOWN
		|| head.func == best_pkg::FN_JOY_DOWN;
	assign is_release = head.func == best_pkg::FN_KEY_UP || head.func == best_pkg::FN_MOUSE_UP
		|| head.func == best_pkg::FN_JOY_UP;
	assign is_read  = head.func == best_pkg::FN_READ_KEY || head.func == best_pkg::FN_READ_MOUSE
		|| head.func == best_pkg::FN_READ_JOY;
	assign is_tick  = head.func == best_pkg::FN_TICK;

	assign out_free = !m_tvalid_q || m_tready;

	// Sequencer: in-range key operations read the key store first, the rest finish from idle once the output is free.
	always_comb begin
		key_re = 1'b0;
		done   = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (head_valid && is_key && head.hit) begin
					key_re = 1'b1;
				end else begin
					done = head_valid && out_free;
				end
			end
			BK_KEY: begin
				done = out_free;
			end
			default: begin
				done = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else if (key_re) begin
			state_q <= BK_KEY;
		end else if (done) begin
			state_q <= BK_IDLE;
		end
	end

	assign pop = done;

	// A key entry is up until first written and ages lazily once a tick has passed it.
	always_comb begin
		if (!key_valid_q[key_addr]) begin
			key_eff = best_pkg::ST_UP;
		end else if (key_fresh_q[key_addr]) begin
			key_eff = key_rd_q;
		end else begin
			key_eff = best_pkg::age_state(key_rd_q);
		end
	end

	// Current state of the addressed entry and the edge it makes.
	always_comb begin
		if (!head.hit) begin
			cur = best_pkg::ST_UP;
		end else if (is_key) begin
			cur = key_eff;
		end else if (is_mouse) begin
			cur = mouse_q[mouse_addr];
		end else if (is_joy) begin
			cur = joy_q[joy_addr];
		end else begin
			cur = best_pkg::ST_UP;
		end
	end

	assign press_hit = is_press && head.hit && cur != best_pkg::ST_DOWN;
	assign rel_hit   = is_release && head.hit && cur != best_pkg::ST_UP;
	assign upd       = press_hit || rel_hit;
	assign new_state = press_hit ? best_pkg::ST_PRESSED : best_pkg::ST_RELEASED;
	assign bs        = is_read ? cur : best_pkg::ST_UP;
	assign key_we    = done && upd && is_key;

	// Next values of the scalar state for the operation being completed.
	always_comb begin
		nxt_cx     = cursor_x_q;
		nxt_cy     = cursor_y_q;
		nxt_ox     = old_x_q;
		nxt_oy     = old_y_q;
		nxt_wheel  = wheel_q;
		nxt_ax     = axis_x_q;
		nxt_ay     = axis_y_q;
		nxt_dx     = dx_q;
		nxt_dy     = dy_q;
		nxt_resync = resync_q;
		nxt_flags  = flags_q;
		unique case (head.func)
			best_pkg::FN_KEY_DOWN, best_pkg::FN_JOY_DOWN: begin
				if (press_hit) begin
					nxt_flags[best_pkg::FLAG_PRESSED] = 1'b1;
					nxt_flags[best_pkg::FLAG_DOWN]    = 1'b1;
				end
			end
			best_pkg::FN_KEY_UP, best_pkg::FN_JOY_UP: begin
				if (rel_hit) begin
					nxt_flags[best_pkg::FLAG_RELEASED] = 1'b1;
					nxt_flags[best_pkg::FLAG_DOWN]     = 1'b0;
				end
			end
			best_pkg::FN_MOVE: begin
				nxt_cx = head.pos_x;
				nxt_cy = head.pos_y;
			end
			best_pkg::FN_WHEEL: begin
				nxt_wheel = head.value;
			end
			best_pkg::FN_AXIS: begin
				if (head.hit && head.idx[0] == 1'b0) begin
					nxt_ax = head.value;
				end else if (head.hit) begin
					nxt_ay = head.value;
				end
			end
			best_pkg::FN_TICK: begin
				nxt_wheel = '0;
				// A pending resync makes the old position the cursor, so the delta is zero.
				if (resync_q) begin
					nxt_dx = '0;
					nxt_dy = '0;
				end else begin
					nxt_dx = 17'(cursor_x_q) - 17'(old_x_q);
					nxt_dy = 17'(cursor_y_q) - 17'(old_y_q);
				end
				nxt_ox     = cursor_x_q;
				nxt_oy     = cursor_y_q;
				nxt_resync = 1'b0;
				nxt_flags  = flags_q & (3'b001 << best_pkg::FLAG_DOWN);
			end
			best_pkg::FN_SET_OLD_X: begin
				nxt_ox = head.value;
			end
			best_pkg::FN_SET_OLD_Y: begin
				nxt_oy = head.value;
			end
			best_pkg::FN_RESYNC: begin
				nxt_resync = 1'b1;
			end
			best_pkg::FN_MOUSE_DOWN, best_pkg::FN_MOUSE_UP, best_pkg::FN_READ_KEY,
			best_pkg::FN_READ_MOUSE, best_pkg::FN_READ_JOY: begin
				nxt_flags = flags_q;
			end
			default: begin
				nxt_flags = flags_q;
			end
		endcase
	end

	// Scalar state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= '0;
			cursor_y_q <= '0;
			old_x_q    <= '0;
			old_y_q    <= '0;
			wheel_q    <= '0;
			axis_x_q   <= '0;
			axis_y_q   <= '0;
			dx_q       <= '0;
			dy_q       <= '0;
			resync_q   <= 1'b0;
			flags_q    <= '0;
		end else if (done) begin
			cursor_x_q <= nxt_cx;
			cursor_y_q <= nxt_cy;
			old_x_q    <= nxt_ox;
			old_y_q    <= nxt_oy;
			wheel_q    <= nxt_wheel;
			axis_x_q   <= nxt_ax;
			axis_y_q   <= nxt_ay;
			dx_q       <= nxt_dx;
			dy_q       <= nxt_dy;
			resync_q   <= nxt_resync;
			flags_q    <= nxt_flags;
		end
	end

	// Mouse and joystick button states sit in flip-flops and age together on a tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MOUSE_BUTTONS; i++) begin
				mouse_q[i] <= best_pkg::ST_UP;
			end
			for (int i = 0; i < JOY_BUTTONS; i++) begin
				joy_q[i] <= best_pkg::ST_UP;
			end
		end else if (done && is_tick) begin
			for (int i = 0; i < MOUSE_BUTTONS; i++) begin
				mouse_q[i] <= best_pkg::age_state(mouse_q[i]);
			end
			for (int i = 0; i < JOY_BUTTONS; i++) begin
				joy_q[i] <= best_pkg::age_state(joy_q[i]);
			end
		end else if (done && upd && is_mouse) begin
			mouse_q[mouse_addr] <= new_state;
		end else if (done && upd && is_joy) begin
			joy_q[joy_addr] <= new_state;
		end
	end

	// Valid and fresh marks of the key store; a tick clears every fresh mark.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_valid_q <= '0;
			key_fresh_q <= '0;
		end else if (done && is_tick) begin
			key_fresh_q <= '0;
		end else if (key_we) begin
			key_valid_q[key_addr] <= 1'b1;
			key_fresh_q[key_addr] <= 1'b1;
		end
	end

	// Key state memory with a registered read port.
	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[key_addr] <= new_state;
		end
		if (key_re) begin
			key_rd_q <= key_mem[key_addr];
		end
	end

	// Output register: holds a finished snapshot until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (done) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			m_tdata_q <= {1'b0, nxt_ay, nxt_ax, nxt_cy, nxt_cx, nxt_dy, nxt_dx, nxt_wheel,
				nxt_flags[best_pkg::FLAG_DOWN], nxt_flags[best_pkg::FLAG_RELEASED],
				nxt_flags[best_pkg::FLAG_PRESSED], bs};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// File: src/button_edge_state_tracker_core.sv
// Channel  | Direction | Ports                         | Contents
// input    | in        | s_tvalid s_tready s_tdata s_tuser | one event or read
// output   | out       | m_tvalid m_tready m_tdata     | one snapshot per input
//
// An in-range key event or key read first reads the key store in the back end and then
// updates it; every other operation, the frame tick included, completes directly from idle.
// A two-entry queue separates intake from execution, and an output register holds
// the snapshot, so either side may stall without stopping the other.
// Reset is asynchronous and active low; the block is ready as soon as reset is released.
module button_edge_state_tracker_core #(
	parameter int KEY_COUNT     = 256,
	parameter int MOUSE_BUTTONS = 4,
	parameter int JOY_BUTTONS   = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// index[7:0], pos_x[23:8], pos_y[39:24], value[55:40]
	input  logic [best_pkg::IN_DATA_W-1:0]  s_tdata,
	// func[3:0]
	input  logic [best_pkg::FUNC_W-1:0]     s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// button_state[1:0], pressed_flag[2], released_flag[3], down_flag[4], wheel_out[20:5],
	// delta_x[37:21], delta_y[54:38], cursor_x[70:55], cursor_y[86:71],
	// axis_x[102:87], axis_y[118:103], zero pad[119]
	output logic [best_pkg::OUT_DATA_W-1:0] m_tdata
);

	best_pkg::item_t in_item;
	best_pkg::item_t head;
	logic            push;
	logic            full;
	logic            pop;
	logic            head_valid;

	// Intake and classification.
	best_front #(
		.KEY_COUNT    (KEY_COUNT),
		.MOUSE_BUTTONS(MOUSE_BUTTONS),
		.JOY_BUTTONS  (JOY_BUTTONS)
	) u_front (
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.full    (full),
		.push    (push),
		.item    (in_item)
	);

	// Queue between intake and execution.
	best_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_item   (in_item),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.head_valid(head_valid)
	);

	// State update and snapshot output.
	best_back #(
		.KEY_COUNT    (KEY_COUNT),
		.MOUSE_BUTTONS(MOUSE_BUTTONS),
		.JOY_BUTTONS  (JOY_BUTTONS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.head_valid(head_valid),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

// File: src/best_checker.sv
module best_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [best_pkg::OUT_DATA_W-1:0] m_tdata
);

	logic [2:0] cnt_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	// Transactions taken in whose snapshot has not yet been delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_acc && !out_acc) begin
			cnt_q <= cnt_q + 3'd1;
		end else if (out_acc && !in_acc) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	// A stalled snapshot stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output valid dropped while stalled");

	// A stalled snapshot keeps its data.
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("output data changed while stalled");

	// No snapshot without an outstanding transaction.
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> cnt_q != 3'd0)
		else $error("output offered with nothing outstanding");

	// Queue plus output register hold at most three transactions.
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd3)
		else $error("too many transactions outstanding");

	// An empty block always takes the next transaction.
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 3'd0 |-> s_tready)
		else $error("idle block not ready");

endmodule

bind button_edge_state_tracker_core best_checker u_best_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

// File: dv/button_edge_state_tracker_core_tb.sv
module button_edge_state_tracker_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int KEY_N   = 256;
	localparam int MOUSE_N = 4;
	localparam int JOY_N   = 12;

	// Output payload laid out as on m_tdata, the highest field first.
	typedef struct packed {
		logic               pad;
		logic signed [15:0] axis_y;
		logic signed [15:0] axis_x;
		logic signed [15:0] cursor_y;
		logic signed [15:0] cursor_x;
		logic signed [16:0] delta_y;
		logic signed [16:0] delta_x;
		logic signed [15:0] wheel_out;
		logic               down_flag;
		logic               released_flag;
		logic               pressed_flag;
		logic [1:0]         button_state;
	} snapshot_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [best_pkg::IN_DATA_W-1:0]  s_tdata = '0;
	logic [best_pkg::FUNC_W-1:0]     s_tuser = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [best_pkg::OUT_DATA_W-1:0] m_tdata;

	// Idle rates in percent for each side of the block.
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned mismatches = 0;

	// Expected snapshots, oldest first.
	snapshot_t snapshot_q[$];

	// Tracker state as the block should hold it.
	logic [1:0]  key_st [KEY_N];
	logic [1:0]  mouse_st [MOUSE_N];
	logic [1:0]  joy_st [JOY_N];
	logic [15:0] cur_x, cur_y, prev_x, prev_y, wheel_v, axis_x_v, axis_y_v;
	logic [16:0] move_dx, move_dy;
	logic        resync_due, fl_pressed, fl_released, fl_down;

	button_edge_state_tracker_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// At the end of a frame a pressed entry settles to down and a released one to up.
	function automatic logic [1:0] settle_state(input logic [1:0] st);
		if (st == best_pkg::ST_PRESSED) begin
			return best_pkg::ST_DOWN;
		end else if (st == best_pkg::ST_RELEASED) begin
			return best_pkg::ST_UP;
		end
		return st;
	endfunction

	function automatic void clear_tracker();
		foreach (key_st[i]) key_st[i] = best_pkg::ST_UP;
		foreach (mouse_st[i]) mouse_st[i] = best_pkg::ST_UP;
		foreach (joy_st[i]) joy_st[i] = best_pkg::ST_UP;
		cur_x = '0; cur_y = '0; prev_x = '0; prev_y = '0;
		wheel_v = '0; axis_x_v = '0; axis_y_v = '0;
		move_dx = '0; move_dy = '0;
		resync_due = 1'b0; fl_pressed = 1'b0; fl_released = 1'b0; fl_down = 1'b0;
	endfunction

	// Applies one event to the tracker state and returns the snapshot it should produce.
	function automatic snapshot_t track_edges(input logic [3:0] fn, input logic [7:0] idx,
			input logic [15:0] px, input logic [15:0] py, input logic [15:0] val);
		snapshot_t s;
		s = '0;
		case (fn)
			best_pkg::FN_KEY_DOWN: begin
				if (key_st[idx] != best_pkg::ST_DOWN) begin
					key_st[idx] = best_pkg::ST_PRESSED;
					fl_pressed = 1'b1;
					fl_down = 1'b1;
				end
			end
			best_pkg::FN_KEY_UP: begin
				if (key_st[idx] != best_pkg::ST_UP) begin
					key_st[idx] = best_pkg::ST_RELEASED;
					fl_released = 1'b1;
					fl_down = 1'b0;
				end
			end
			// Mouse edges never touch the flags.
			best_pkg::FN_MOUSE_DOWN: begin
				if (idx < MOUSE_N) begin
					if (mouse_st[idx] != best_pkg::ST_DOWN) begin
						mouse_st[idx] = best_pkg::ST_PRESSED;
					end
				end
			end
			best_pkg::FN_MOUSE_UP: begin
				if (idx < MOUSE_N) begin
					if (mouse_st[idx] != best_pkg::ST_UP) begin
						mouse_st[idx] = best_pkg::ST_RELEASED;
					end
				end
			end
			best_pkg::FN_JOY_DOWN: begin
				if (idx < JOY_N) begin
					if (joy_st[idx] != best_pkg::ST_DOWN) begin
						joy_st[idx] = best_pkg::ST_PRESSED;
						fl_pressed = 1'b1;
						fl_down = 1'b1;
					end
				end
			end
			best_pkg::FN_JOY_UP: begin
				if (idx < JOY_N) begin
					if (joy_st[idx] != best_pkg::ST_UP) begin
						joy_st[idx] = best_pkg::ST_RELEASED;
						fl_released = 1'b1;
						fl_down = 1'b0;
					end
				end
			end
			best_pkg::FN_MOVE: begin
				cur_x = px;
				cur_y = py;
			end
			best_pkg::FN_WHEEL: wheel_v = val;
			best_pkg::FN_AXIS: begin
				if (idx == 8'd0) begin
					axis_x_v = val;
				end else if (idx == 8'd1) begin
					axis_y_v = val;
				end
			end
			// Frame tick: clear the wheel, settle every store, work out the delta, keep the down flag.
			best_pkg::FN_TICK: begin
				wheel_v = '0;
				foreach (key_st[i]) key_st[i] = settle_state(key_st[i]);
				foreach (mouse_st[i]) mouse_st[i] = settle_state(mouse_st[i]);
				foreach (joy_st[i]) joy_st[i] = settle_state(joy_st[i]);
				if (resync_due) begin
					prev_x = cur_x;
					prev_y = cur_y;
					resync_due = 1'b0;
				end
				move_dx = {cur_x[15], cur_x} - {prev_x[15], prev_x};
				move_dy = {cur_y[15], cur_y} - {prev_y[15], prev_y};
				prev_x = cur_x;
				prev_y = cur_y;
				fl_pressed = 1'b0;
				fl_released = 1'b0;
			end
			best_pkg::FN_READ_KEY: s.button_state = key_st[idx];
			best_pkg::FN_READ_MOUSE: begin
				s.button_state = (idx < MOUSE_N) ? mouse_st[idx] : best_pkg::ST_UP;
			end
			best_pkg::FN_READ_JOY: begin
				s.button_state = (idx < JOY_N) ? joy_st[idx] : best_pkg::ST_UP;
			end
			best_pkg::FN_SET_OLD_X: prev_x = val;
			best_pkg::FN_SET_OLD_Y: prev_y = val;
			best_pkg::FN_RESYNC: resync_due = 1'b1;
			default: ;
		endcase
		s.pressed_flag = fl_pressed;
		s.released_flag = fl_released;
		s.down_flag = fl_down;
		s.wheel_out = wheel_v;
		s.delta_x = move_dx;
		s.delta_y = move_dy;
		s.cursor_x = cur_x;
		s.cursor_y = cur_y;
		s.axis_x = axis_x_v;
		s.axis_y = axis_y_v;
		return s;
	endfunction

	// Offers one event, waits for its transaction and records the expected snapshot.
	task automatic post_event(input logic [3:0] fn, input logic [7:0] idx,
			input logic [15:0] px, input logic [15:0] py, input logic [15:0] val);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= fn;
		s_tdata <= {val, py, px, idx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		snapshot_q.push_back(track_edges(fn, idx, px, py, val));
	endtask

	// Key and joystick edges, mouse buttons, out-of-range indexes and reads.
	task automatic test_button_edges();
		post_event(best_pkg::FN_KEY_DOWN, 8'd0, 16'h0000, 16'h0000, 16'h0000);
		post_event(best_pkg::FN_KEY_DOWN, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		post_event(best_pkg::FN_READ_KEY, 8'd255, 16'h0000, 16'h0000, 16'h0000);
		post_event(best_pkg::FN_KEY_DOWN, 8'd0, 16'h0000, 16'h0000, 16'h0000);
		post_event(best_pkg::FN_KEY_UP, 8'd0, 16'h0000, 16'h0000, 16'h0000);
		post_event(best_pkg::FN_MOUSE_DOWN, 8'd3, 16'h0000, 16'h0000, 16'h0000);
		post_event(best_pkg::FN_MOUSE_DOWN, 8'd4, 16'h0000, 16'h0000, 16'h0000);
		post_event(best_pkg::FN_READ_MOUSE, 8'd4, 16'h0000, 16'h0000, 16'h0000);
		post_event(best_pkg::FN_JOY_DOWN, 8'd11, 16'h0000, 16'h0000, 16'h0000);
		post_event(best_pkg::FN_JOY_DOWN, 8'd12, 16'h0000, 16'h0000, 16'h0000);
		post_event(best_pkg::FN_READ_JOY, 8'd200, 16'h0000, 16'h0000, 16'h0000);
		post_event(best_pkg::FN_TICK, 8'd0, 16'h0000, 16'h0000, 16'h0000);
		post_event(best_pkg::FN_READ_KEY, 8'd0, 16'h0000, 16'h0000, 16'h0000);
		post_event(best_pkg::FN_READ_MOUSE, 8'd3, 16'h0000, 16'h0000, 16'h0000);
		post_event(best_pkg::FN_JOY_UP, 8'd11, 16'h0000, 16'h0000, 16'h0000);
		post_event(best_pkg::FN_MOUSE_UP, 8'd3, 16'h0000, 16'h0000, 16'h0000);
	endtask

	// Cursor extremes, wheel, axes, old position writes and resync.
	task automatic test_pointer_and_axes();
		post_event(best_pkg::FN_MOVE, 8'd0, 16'h7FFF, 16'h8000, 16'h0000);
		post_event(best_pkg::FN_WHEEL, 8'd0, 16'h0000, 16'h0000, 16'h8000);
		post_event(best_pkg::FN_AXIS, 8'd0, 16'h0000, 16'h0000, 16'h7FFF);
		post_event(best_pkg::FN_AXIS, 8'd1, 16'h0000, 16'h0000, 16'h8000);
		post_event(best_pkg::FN_AXIS, 8'd2, 16'h0000, 16'h0000, 16'h1234);
		post_event(best_pkg::FN_SET_OLD_X, 8'd0, 16'h0000, 16'h0000, 16'h8000);
		post_event(best_pkg::FN_SET_OLD_Y, 8'd0, 16'h0000, 16'h0000, 16'h7FFF);
		post_event(best_pkg::FN_TICK, 8'd0, 16'h0000, 16'h0000, 16'h0000);
		post_event(best_pkg::FN_RESYNC, 8'd0, 16'h0000, 16'h0000, 16'h0000);
		post_event(best_pkg::FN_MOVE, 8'd0, 16'h8000, 16'h7FFF, 16'h0000);
		post_event(best_pkg::FN_TICK, 8'd0, 16'h0000, 16'h0000, 16'h0000);
	endtask

	// Key indexes are drawn mostly from both ends of the range so edges meet again.
	function automatic logic [7:0] pick_key();
		if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, 7)) | ($urandom_range(0, 1) ? 8'hF8 : 8'h00);
	endfunction

	function automatic logic [7:0] pick_button(input int unsigned count);
		if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, count - 1));
	endfunction

	// Random traffic weighted towards button edges, with ticks often enough to age them.
	task automatic test_random_traffic(input int unsigned count, input int unsigned send_pct,
			input int unsigned recv_pct);
		int unsigned pick;
		logic [3:0]  fn;
		logic [7:0]  idx;
		logic [15:0] px, py, val;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			px = 16'($urandom);
			py = 16'($urandom);
			val = 16'($urandom);
			idx = 8'($urandom_range(0, 255));
			if (pick < 30) begin
				fn = $urandom_range(0, 1) ? best_pkg::FN_KEY_DOWN : best_pkg::FN_KEY_UP;
				idx = pick_key();
			end else if (pick < 40) begin
				fn = $urandom_range(0, 1) ? best_pkg::FN_MOUSE_DOWN : best_pkg::FN_MOUSE_UP;
				idx = pick_button(MOUSE_N);
			end else if (pick < 52) begin
				fn = $urandom_range(0, 1) ? best_pkg::FN_JOY_DOWN : best_pkg::FN_JOY_UP;
				idx = pick_button(JOY_N);
			end else if (pick < 60) begin
				fn = best_pkg::FN_READ_KEY;
				idx = pick_key();
			end else if (pick < 64) begin
				fn = best_pkg::FN_READ_MOUSE;
				idx = pick_button(MOUSE_N);
			end else if (pick < 69) begin
				fn = best_pkg::FN_READ_JOY;
				idx = pick_button(JOY_N);
			end else if (pick < 77) begin
				fn = best_pkg::FN_MOVE;
			end else if (pick < 81) begin
				fn = best_pkg::FN_WHEEL;
			end else if (pick < 86) begin
				fn = best_pkg::FN_AXIS;
				if ($urandom_range(0, 3) != 0) idx = 8'($urandom_range(0, 1));
			end else if (pick < 94) begin
				fn = best_pkg::FN_TICK;
			end else if (pick < 96) begin
				fn = best_pkg::FN_SET_OLD_X;
			end else if (pick < 98) begin
				fn = best_pkg::FN_SET_OLD_Y;
			end else begin
				fn = best_pkg::FN_RESYNC;
			end
			post_event(fn, idx, px, py, val);
		end
	endtask

	task automatic compare_field(input string name, input logic [16:0] want,
			input logic [16:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	// The receiver stalls at random; the rate follows the current phase.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Every output transaction is matched against the oldest expected snapshot.
	always @(posedge clk) begin : check_snapshot
		snapshot_t got;
		snapshot_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = snapshot_t'(m_tdata);
			if (snapshot_q.size() == 0) begin
				$error("snapshot arrived with none expected: 0x%0h", m_tdata);
				mismatches++;
			end else begin
				want = snapshot_q.pop_front();
				compare_field("button_state", 17'(want.button_state), 17'(got.button_state));
				compare_field("pressed_flag", 17'(want.pressed_flag), 17'(got.pressed_flag));
				compare_field("released_flag", 17'(want.released_flag),
					17'(got.released_flag));
				compare_field("down_flag", 17'(want.down_flag), 17'(got.down_flag));
				compare_field("wheel_out", 17'(want.wheel_out), 17'(got.wheel_out));
				compare_field("delta_x", want.delta_x, got.delta_x);
				compare_field("delta_y", want.delta_y, got.delta_y);
				compare_field("cursor_x", 17'(want.cursor_x), 17'(got.cursor_x));
				compare_field("cursor_y", 17'(want.cursor_y), 17'(got.cursor_y));
				compare_field("axis_x", 17'(want.axis_x), 17'(got.axis_x));
				compare_field("axis_y", 17'(want.axis_y), 17'(got.axis_y));
			end
		end
	end

	// Sequence of tests, drain and verdict.
	initial begin
		clear_tracker();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 6;
		recv_idle_pct = 51;
		test_button_edges();
		test_pointer_and_axes();
		test_random_traffic(445, 6, 51);
		test_random_traffic(445, 51, 6);
		test_random_traffic(435, 0, 0);
		s_tvalid <= 1'b0;
		while (snapshot_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("button_edge_state_tracker_core test passed");
		end else begin
			$display("button_edge_state_tracker_core test failed");
		end
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#1_000_000;
		$display("button_edge_state_tracker_core test failed");
		$finish;
	end

endmodule

// File: button_edge_state_tracker_core.f
src/best_pkg.sv
src/best_front.sv
src/best_fifo.sv
src/best_back.sv
src/button_edge_state_tracker_core.sv
src/best_checker.sv
dv/button_edge_state_tracker_core_tb.sv
